[rtl/czd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// czd_pkg: shared types and constants of the COBS / zero pair decoder
// Result record, push bundle between decoder and result buffer, code limits.
// ----------------------------------------------------------------------------
package czd_pkg;

	// Codes above this mark a zero pair in pair mode
	localparam logic [7:0] PAIR_BASE   = 8'hE0;
	// Frame length limits, in encoded bytes
	localparam logic [8:0] LIMIT_PLAIN = 9'd255;
	localparam logic [8:0] LIMIT_PAIR  = 9'd224;
	localparam logic [7:0] ZERO_BYTE   = 8'h00;

	typedef logic [8:0] pos_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_data;
		logic       last;
		logic       too_long;
	} result_t;

	// Up to two results written into the buffer in one cycle
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage
`default_nettype wire

[rtl/czd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// czd_if: channel interfaces of the decoder
// Encoded byte input, decoded result output and the mode register write port.
// ----------------------------------------------------------------------------
interface czd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       frame_end;

	modport source (output valid, output in_byte, output frame_end, input ready);
	modport sink   (input valid, input in_byte, input frame_end, output ready);
endinterface

interface czd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_data;
	logic       last;
	logic       too_long;

	modport source (output valid, output out_byte, output has_data, output last,
		output too_long, input ready);
	modport sink   (input valid, input out_byte, input has_data, input last,
		input too_long, output ready);
endinterface

interface czd_cfg_if;
	logic valid;
	logic ready;
	logic zero_pair_mode;

	modport source (output valid, output zero_pair_mode, input ready);
	modport sink   (input valid, input zero_pair_mode, output ready);
endinterface
`default_nettype wire

[rtl/czd_result_buf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// czd_result_buf: three-entry result queue in front of the output channel
// Takes zero, one or two results a cycle and presents one per transaction.
// ----------------------------------------------------------------------------
module czd_result_buf
	import czd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  push_t       push,
	output logic        room,
	czd_out_if.source   out_ch
);

	localparam int DEPTH = 3;

	result_t    mem_q [DEPTH];
	logic [1:0] rd_ptr_q;
	logic [1:0] wr_ptr_q;
	logic [1:0] count_q;
	logic       pop;
	result_t    head;

	function automatic logic [1:0] ptr_inc(input logic [1:0] p);
		ptr_inc = (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
	endfunction

	// Room for a pair whenever at most one entry is held
	assign room = !count_q[1];
	assign pop  = out_ch.valid && out_ch.ready;
	assign head = mem_q[rd_ptr_q];

	assign out_ch.valid    = (count_q != 2'd0);
	assign out_ch.out_byte = head.out_byte;
	assign out_ch.has_data = head.has_data;
	assign out_ch.last     = head.last;
	assign out_ch.too_long = head.too_long;

	// Store pushed results at the write pointer
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[ptr_inc(wr_ptr_q)] <= push.second;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 2'd0;
			wr_ptr_q <= 2'd0;
			count_q  <= 2'd0;
		end else begin
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push.count == 2'd1) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end else if (push.count == 2'd2) begin
				wr_ptr_q <= ptr_inc(ptr_inc(wr_ptr_q));
			end
			count_q <= count_q + push.count - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

[rtl/cobs_zpe_stream_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_zpe_stream_decoder: streaming COBS decoder with zero pair elimination
// Decodes one encoded byte per transaction into zero, one or two results.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one encoded byte per transaction, frame_end on the last one.
//   out_ch carries decoded bytes; the final result of a frame has last set,
//   with has_data low for a bare end marker and too_long set when the frame
//   passed 255 bytes (plain) or 224 bytes (pair mode).
//   cfg_ch writes zero_pair_mode and is always ready; the user must write it
//   between frames while the block is idle, which the block does not enforce.
// A result is written into the result queue when its input transaction is
//   accepted. Throughput: one byte per cycle while in_ch.ready is high; a code
//   byte closing a zero pair pushes two results, and the three-entry result
//   queue then holds in_ch.ready low until the receiver takes a result.
// in_ch.ready is high while the result queue holds at most one entry, so a
//   stalled receiver stops intake after at most three further results.
// Reset clears frame state, the mode register and the result queue; there is
//   no clearing pass.
// ----------------------------------------------------------------------------
module cobs_zpe_stream_decoder
	import czd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	czd_in_if.sink    in_ch,
	czd_out_if.source out_ch,
	czd_cfg_if.sink   cfg_ch
);

	logic       mode_q;
	pos_t       pos_q;
	pos_t       ncp_q;
	logic       pair_q;
	logic       ovf_q;

	pos_t       pos_d;
	pos_t       ncp_d;
	logic       pair_d;
	logic       ovf_d;
	pos_t       limit;
	logic       code_pair;
	pos_t       code_len;
	logic       accept;
	logic       room;
	push_t      push;
	result_t    zero_res;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = room;
	assign accept       = in_ch.valid && in_ch.ready;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			mode_q <= cfg_ch.zero_pair_mode;
		end
	end

	// Decode one byte: next frame state and the results it gives
	always_comb begin
		limit     = mode_q ? LIMIT_PAIR : LIMIT_PLAIN;
		code_pair = mode_q && (in_ch.in_byte > PAIR_BASE);
		code_len  = code_pair ? {1'b0, in_ch.in_byte - PAIR_BASE} : {1'b0, in_ch.in_byte};
		zero_res  = '{out_byte: ZERO_BYTE, has_data: 1'b1, last: 1'b0, too_long: 1'b0};

		pos_d       = pos_q;
		ncp_d       = ncp_q;
		pair_d      = pair_q;
		ovf_d       = ovf_q || (pos_q >= limit);
		push.count  = 2'd0;
		push.first  = zero_res;
		push.second = zero_res;

		priority if (ovf_d) begin
			// drop bytes past the limit
		end else if (pos_q == '0) begin
			ncp_d  = code_len;
			pair_d = code_pair;
			pos_d  = 9'd1;
		end else if (pos_q == ncp_q) begin
			push.count = pair_q ? 2'd2 : 2'd1;
			ncp_d      = ncp_q + code_len;
			pair_d     = code_pair;
			pos_d      = pos_q + 9'd1;
		end else begin
			push.count          = 2'd1;
			push.first.out_byte = in_ch.in_byte;
			pos_d               = pos_q + 9'd1;
		end

		// Close the frame: mark the final result and restart
		if (in_ch.frame_end) begin
			if (ovf_d) begin
				push.count = 2'd1;
				push.first = '{out_byte: ZERO_BYTE, has_data: 1'b0, last: 1'b1,
					too_long: 1'b1};
			end else if (push.count == 2'd0) begin
				push.count = 2'd1;
				push.first = '{out_byte: ZERO_BYTE, has_data: 1'b0, last: 1'b1,
					too_long: 1'b0};
			end else if (push.count == 2'd1) begin
				push.first.last = 1'b1;
			end else begin
				push.second.last = 1'b1;
			end
			pos_d  = '0;
			ncp_d  = '0;
			pair_d = 1'b0;
			ovf_d  = 1'b0;
		end

		if (!accept) begin
			push.count = 2'd0;
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ncp_q  <= '0;
			pair_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (accept) begin
			pos_q  <= pos_d;
			ncp_q  <= ncp_d;
			pair_q <= pair_d;
			ovf_q  <= ovf_d;
		end
	end

	czd_result_buf u_result_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.out_ch (out_ch)
	);

endmodule
`default_nettype wire

[rtl/czd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// czd_checker: port-level checks of the decoder
// Output hold under stall, end-marker coding and intake while drained.
// ----------------------------------------------------------------------------
module czd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       has_data,
	input wire logic       last,
	input wire logic       too_long
);

	// Hold a stalled transaction unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(has_data) && $stable(last) && $stable(too_long))
		else $error("output transaction changed while stalled");

	// A result without data is always a zero end marker
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_data |-> last && (out_byte == 8'h00))
		else $error("bare result is not a frame end marker");

	// An over-long frame ends with a bare marker
	a_too_long: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_long |-> !has_data && last)
		else $error("too_long on a data result");

	// An empty result queue always takes input
	a_drained_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with nothing pending");

endmodule

bind cobs_zpe_stream_decoder czd_checker u_czd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.has_data  (out_ch.has_data),
	.last      (out_ch.last),
	.too_long  (out_ch.too_long)
);
`default_nettype wire
